/* sv/vcfr_pkg.sv */
// Package with the frame layout constants, register indexes and types of the receiver.
`default_nettype none
package vcfr_pkg;

    localparam int FrameLen = 11;
    localparam int CheckPos = 9;
    localparam int TailPos  = 10;
    localparam int ChainLen = 10;
    localparam int PosWidth = 4;

    localparam logic [7:0] HeaderReset = 8'd123;
    localparam logic [7:0] TailReset   = 8'd125;

    typedef enum logic [0:0] {
        REG_HEADER = 1'b0,
        REG_TAIL   = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] speed_z;
        logic signed [15:0] speed_y;
        logic signed [15:0] speed_x;
    } speed_t;

endpackage
`default_nettype wire

/* sv/vcfr_cell.sv */
// One byte cell of the frame shift chain.
`default_nettype none
module vcfr_cell
    import vcfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       shift_en,
    input  wire logic [7:0] d_in,
    output logic      [7:0] q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = shift_en ? d_in : byte_reg;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign q = byte_reg;

endmodule
`default_nettype wire

/* sv/velocity_command_frame_receiver_top.sv */
// Top level of the velocity command frame receiver.
`default_nettype none
// The receiver takes one byte per clock cycle while s_tready is high and assembles 11-byte frames
// that start with the header byte. Each frame byte but the last enters a row of ten byte cells
// while a running XOR and a position counter follow the frame, so the eleventh byte is checked in
// the cycle it arrives; an accepted frame goes to the output register, or to the skid entry while
// that is occupied, as three signed big-endian speeds. Results are at least eleven items apart; a
// two-entry output buffer holds them, and s_tready falls only while two results are waiting to be
// taken. Bytes presented with startup_hold set are accepted and leave no trace.
module velocity_command_frame_receiver_top
    import vcfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte [7:0]
    input  wire logic [0:0]  s_tuser,   // startup_hold [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata    // speed_x [15:0], speed_y [31:16], speed_z [47:32]
);

    logic [7:0]          header_reg, header_next;
    logic [7:0]          tail_reg, tail_next;
    logic [PosWidth-1:0] pos_reg, pos_next;
    logic [7:0]          xor_reg, xor_next;
    logic                out_valid_reg, out_valid_next;
    speed_t              out_data_reg, out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    speed_t              skid_data_reg, skid_data_next;

    logic [7:0] cell_q [ChainLen];
    logic       shift_en;
    logic       in_acc;
    logic       pop;
    logic       push;
    logic       frame_end;
    speed_t     new_speed;

    localparam logic [PosWidth-1:0] PosZero  = '0;
    localparam logic [PosWidth-1:0] PosCheck = PosWidth'(CheckPos);
    localparam logic [PosWidth-1:0] PosTail  = PosWidth'(TailPos);

    assign s_tready = !skid_valid_reg;
    assign in_acc   = s_tvalid && s_tready && !s_tuser[0];
    assign pop      = m_tvalid && m_tready;

    assign frame_end = in_acc && (pos_reg >= PosTail);
    assign shift_en  = in_acc && (pos_reg < PosTail)
                       && ((pos_reg != PosZero) || (s_tdata == header_reg));

    generate
        for (genvar i = 0; i < ChainLen; i++)
        begin : g_chain
            vcfr_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d_in     ((i == ChainLen - 1) ? s_tdata : cell_q[(i + 1) % ChainLen]),
                .q        (cell_q[i])
            );
        end
    endgenerate

    assign new_speed.speed_x = {cell_q[3], cell_q[4]};
    assign new_speed.speed_y = {cell_q[5], cell_q[6]};
    assign new_speed.speed_z = {cell_q[7], cell_q[8]};
    assign push = frame_end && (s_tdata == tail_reg) && (cell_q[CheckPos] == xor_reg);

    always_comb
    begin
        header_next = header_reg;
        tail_next   = tail_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_HEADER: header_next = cfg_data;
                REG_TAIL:   tail_next   = cfg_data;
                default:    header_next = header_reg;
            endcase
        end

        pos_next = pos_reg;
        xor_next = xor_reg;
        if (frame_end)
        begin
            pos_next = PosZero;
        end
        else if (shift_en)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == PosZero)
            begin
                xor_next = s_tdata;
            end
            else if (pos_reg < PosCheck)
            begin
                xor_next = xor_reg ^ s_tdata;
            end
        end

        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg)
        begin
            if (pop && push)
            begin
                out_data_next = new_speed;
            end
            else if (pop)
            begin
                out_valid_next = 1'b0;
            end
            else if (push)
            begin
                skid_data_next  = new_speed;
                skid_valid_next = 1'b1;
            end
        end
        else if (push)
        begin
            out_data_next  = new_speed;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg     <= HeaderReset;
            tail_reg       <= TailReset;
            pos_reg        <= PosZero;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            header_reg     <= header_next;
            tail_reg       <= tail_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xor_reg       <= xor_next;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= PosTail)
        else $error("Frame position beyond the tail byte.");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry held while the output register is empty.");

    a_push_spacing: assert property (@(posedge clk) disable iff (!rst_n) push |=> !push)
        else $error("Two results produced in consecutive cycles.");

    a_push_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (pos_reg == PosZero))
        else $error("Position not cleared after an accepted frame.");

endmodule
`default_nettype wire
